// ===== hdl/tq_pkg.sv =====
package tq_pkg;

  localparam int unsigned DefCapacity = 256;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned EntryW = 2 * ByteW;

  typedef enum logic [FuncW-1:0] {
    FnInsert = 3'd0,
    FnPop    = 3'd1,
    FnRemove = 3'd2,
    FnLookup = 3'd3,
    FnClear  = 3'd4
  } func_e;

  typedef enum logic [StatW-1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] item_value;
    logic [ByteW-1:0] item_tag;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [ByteW-1:0] result_value;
    logic [ByteW-1:0] assigned_tag;
  } rsp_t;

endpackage

// ===== hdl/tq_req_if.sv =====
interface tq_req_if;
  import tq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tq_rsp_if.sv =====
interface tq_rsp_if;
  import tq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tq_ram.sv =====
module tq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/tq_ctrl.sv =====
module tq_ctrl #(
  parameter int unsigned Capacity = tq_pkg::DefCapacity
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  tq_req_if.sink                                          req,
  tq_rsp_if.source                                        rsp,
  output logic                                            mem_we_o,
  output logic [((Capacity > 1) ? $clog2(Capacity) : 1)-1:0] mem_waddr_o,
  output logic [tq_pkg::EntryW-1:0]                       mem_wdata_o,
  output logic [((Capacity > 1) ? $clog2(Capacity) : 1)-1:0] mem_raddr_o,
  input  logic [tq_pkg::EntryW-1:0]                       mem_rdata_i
);
  import tq_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  typedef enum logic [2:0] {
    SIdle, SScan, SShift, SResp
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q;
  req_t            req_q;
  rsp_t            rsp_q;
  logic            rd_pend_q;

  logic [ByteW-1:0] rd_val, rd_tag;
  assign rd_val = mem_rdata_i[EntryW-1:ByteW];
  assign rd_tag = mem_rdata_i[ByteW-1:0];

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = (state_q == SResp);
  assign rsp.data  = rsp_q;

  // read address: entry idx in scan and in shift
  logic [CntW-1:0] rd_idx;
  always_comb begin
    rd_idx = idx_q;
    if (state_q == SIdle) rd_idx = '0;
  end
  assign mem_raddr_o = rd_idx[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      count_q    <= '0;
      idx_q      <= '0;
      rd_pend_q  <= 1'b0;
      mem_we_o   <= 1'b0;
    end else begin
      mem_we_o <= 1'b0;
      case (state_q)
        SIdle: begin
          if (req.valid) begin
            req_q     <= req.data;
            rsp_q     <= '{status: StMiss, result_value: '0, assigned_tag: '0};
            idx_q     <= '0;
            rd_pend_q <= 1'b0;
            state_q   <= SResp;
            case (req.data.func)
              FnInsert: begin
                if (count_q >= CapCnt) begin
                  rsp_q.status <= StFull;
                end else begin
                  mem_we_o     <= 1'b1;
                  mem_waddr_o  <= count_q[AddrW-1:0];
                  mem_wdata_o  <= {req.data.item_value, ByteW'(count_q)};
                  count_q      <= count_q + 1'b1;
                  rsp_q.status <= StOk;
                  rsp_q.assigned_tag <= ByteW'(count_q);
                end
              end
              FnPop, FnRemove, FnLookup: begin
                if (count_q != '0) state_q <= SScan;
              end
              FnClear: begin
                count_q      <= '0;
                rsp_q.status <= StOk;
              end
              default: ;
            endcase
          end
        end
        SScan: begin
          // read data for entry idx arrives in the cycle after its address is presented
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            if (req_q.func == FnPop || rd_tag == req_q.item_tag) begin
              rsp_q.status <= StOk;
              if (req_q.func != FnRemove) rsp_q.result_value <= rd_val;
              if (req_q.func == FnLookup) begin
                state_q <= SResp;
              end else begin
                idx_q      <= idx_q + 1'b1;
                state_q    <= SShift;
              end
            end else if (idx_q + 1'b1 >= count_q) begin
              state_q <= SResp;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        SShift: begin
          // move entry idx down to idx-1 until the tail
          if (idx_q >= count_q) begin
            count_q <= count_q - 1'b1;
            state_q <= SResp;
          end else if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q   <= 1'b0;
            mem_we_o    <= 1'b1;
            mem_waddr_o <= AddrW'(idx_q - 1'b1);
            mem_wdata_o <= mem_rdata_i;
            idx_q       <= idx_q + 1'b1;
          end
        end
        SResp: begin
          if (rsp.ready) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== hdl/tagged_queue_with_remove_and_lookup.sv =====
// channel  dir  payload                                  transfer when
// req_i    in   func, item_value, item_tag               valid && ready
// rsp_o    out  status, result_value, assigned_tag       valid && ready
// insert, clear and bad codes: answered straight from idle, with no memory read
// pop/remove/lookup: scan from the head, comparing each entry once its read data
// returns from the registered memory; pop/remove then shift later entries down
// one operation in flight; ready is low until the response is taken
// reset empties the queue at once, memory contents are not cleared
module tagged_queue_with_remove_and_lookup #(
  parameter int unsigned Capacity = tq_pkg::DefCapacity
) (
  input logic      clk_i,
  input logic      rst_ni,
  tq_req_if.sink   req_i,
  tq_rsp_if.source rsp_o
);
  import tq_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  tq_ctrl #(.Capacity(Capacity)) u_ctrl (
    .clk_i, .rst_ni, .req(req_i), .rsp(rsp_o),
    .mem_we_o(we), .mem_waddr_o(waddr), .mem_wdata_o(wdata),
    .mem_raddr_o(raddr), .mem_rdata_i(rdata)
  );

  tq_ram #(.Width(EntryW), .Depth(1 << AddrW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready) else $error("accept while responding");
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.status == StFull |->
    rsp_o.data.result_value == '0 && rsp_o.data.assigned_tag == '0)
    else $error("full response carries data");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.data))
    else $error("response dropped");
endmodule

// ===== tb/sv/tagged_queue_with_remove_and_lookup_tb.sv =====
`timescale 1ns / 100ps

module tagged_queue_with_remove_and_lookup_tb;
  import tq_pkg::*;

  localparam int unsigned Cap = DefCapacity;

  logic clk_i;
  logic rst_ni;

  tq_req_if req_if ();
  tq_rsp_if rsp_if ();

  tagged_queue_with_remove_and_lookup #(.Capacity(Cap)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow queue
  logic [ByteW-1:0] q_vals[$];
  logic [ByteW-1:0] q_tags[$];
  rsp_t             rsp_pending[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          n_mismatch    = 0;
  bit          drain_mode    = 1'b0;

  function automatic rsp_t queue_op(req_t r);
    rsp_t o;
    int   pos;
    o = '0;
    o.status = StMiss;
    pos = -1;
    if (r.func == FnRemove || r.func == FnLookup) begin
      for (int i = 0; i < q_tags.size(); i++) begin
        if (pos < 0 && q_tags[i] == r.item_tag) pos = i;
      end
    end
    case (r.func)
      FnInsert: begin
        if (q_vals.size() >= Cap) begin
          o.status = StFull;
        end else begin
          o.assigned_tag = ByteW'(q_vals.size());
          q_tags.push_back(ByteW'(q_vals.size()));
          q_vals.push_back(r.item_value);
          o.status = StOk;
        end
      end
      FnPop: begin
        if (q_vals.size() > 0) begin
          o.result_value = q_vals.pop_front();
          void'(q_tags.pop_front());
          o.status = StOk;
        end
      end
      FnRemove: begin
        if (pos >= 0) begin
          q_vals.delete(pos);
          q_tags.delete(pos);
          o.status = StOk;
        end
      end
      FnLookup: begin
        if (pos >= 0) begin
          o.result_value = q_vals[pos];
          o.status = StOk;
        end
      end
      FnClear: begin
        q_vals.delete();
        q_tags.delete();
        o.status = StOk;
      end
      default: ;
    endcase
    return o;
  endfunction

  // valid stays high after a transfer until the next item or an idle cycle
  task automatic send_op(logic [FuncW-1:0] f, logic [ByteW-1:0] v, logic [ByteW-1:0] t);
    req_t r;
    r.func = f;
    r.item_value = v;
    r.item_tag = t;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    rsp_pending.push_back(queue_op(r));
  endtask

  // response checker and ready driver
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_pending.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected response %p", rsp_if.data);
        end else begin
          exp_r = rsp_pending.pop_front();
          if (rsp_if.data.status !== exp_r.status ||
              rsp_if.data.result_value !== exp_r.result_value ||
              rsp_if.data.assigned_tag !== exp_r.assigned_tag) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp st=%0d val=%0d tag=%0d got st=%0d val=%0d tag=%0d",
                       exp_r.status, exp_r.result_value, exp_r.assigned_tag,
                       rsp_if.data.status, rsp_if.data.result_value,
                       rsp_if.data.assigned_tag);
          end
        end
      end
      rsp_if.ready <= drain_mode || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [ByteW-1:0] pick_tag();
    if (q_tags.size() > 0 && $urandom_range(3) != 0)
      return q_tags[$urandom_range(q_tags.size() - 1)];
    return ByteW'($urandom);
  endfunction

  task automatic test_directed();
    send_op(FnPop, 8'hff, 8'hff);
    send_op(FnRemove, 8'h00, 8'h00);
    send_op(FnLookup, 8'h00, 8'h00);
    send_op(FnClear, 8'h00, 8'h00);
    send_op(FnInsert, 8'h00, 8'hff);
    send_op(FnInsert, 8'hff, 8'h00);
    send_op(FnInsert, 8'h5a, 8'h00);
    send_op(FnLookup, 8'h00, 8'h00);  // hit on a zero value
    send_op(FnLookup, 8'h00, 8'h02);
    send_op(FnPop, 8'h00, 8'h00);
    send_op(FnInsert, 8'ha5, 8'h00);  // tag 2 again, duplicate
    send_op(FnLookup, 8'h00, 8'h02);
    send_op(FnRemove, 8'h00, 8'h02);
    send_op(FnLookup, 8'h00, 8'h02);
    send_op(FnRemove, 8'h00, 8'h77);
    send_op(3'd5, 8'hff, 8'hff);
    send_op(3'd6, 8'h00, 8'h00);
    send_op(3'd7, 8'h12, 8'h34);
    send_op(FnClear, 8'h00, 8'h00);
    send_op(FnClear, 8'h00, 8'h00);
  endtask

  // fill to capacity, refuse one more, then drain
  task automatic test_full();
    for (int i = 0; i <= Cap; i++) send_op(FnInsert, ByteW'($urandom), ByteW'($urandom));
    send_op(FnLookup, 8'h00, 8'hff);
    send_op(FnRemove, 8'h00, 8'h80);
    send_op(FnInsert, 8'h11, 8'h00);
    send_op(FnInsert, 8'h22, 8'h00);
    for (int i = 0; i < 4; i++) send_op(FnPop, 8'h00, 8'h00);
    send_op(FnClear, 8'h00, 8'h00);
  endtask

  task automatic test_random(int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 40)       send_op(FnInsert, ByteW'($urandom), ByteW'($urandom));
      else if (k < 55)  send_op(FnPop, ByteW'($urandom), ByteW'($urandom));
      else if (k < 72)  send_op(FnRemove, ByteW'($urandom), pick_tag());
      else if (k < 92)  send_op(FnLookup, ByteW'($urandom), pick_tag());
      else if (k < 94)  send_op(FnClear, ByteW'($urandom), ByteW'($urandom));
      else              send_op(FuncW'($urandom_range(7, 5)), ByteW'($urandom),
                                ByteW'($urandom));
    end
  endtask

  initial begin
    int wait_cnt;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 8;
    recv_idle_pct = 48;
    test_directed();
    test_full();
    test_random(350);
    send_idle_pct = 48;
    recv_idle_pct = 8;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    req_if.valid <= 1'b0;
    drain_mode = 1'b1;
    wait_cnt = 0;
    while (rsp_pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (1200) @(posedge clk_i);
    if (n_mismatch == 0 && rsp_pending.size() == 0) begin
      $display("PASS tagged_queue_with_remove_and_lookup");
    end else begin
      $display("FAIL tagged_queue_with_remove_and_lookup");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL tagged_queue_with_remove_and_lookup");
    $finish;
  end

endmodule
